// ----- rtl/sem_pkg.sv -----
`default_nettype none
package sem_pkg;

  // pixel and arithmetic widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned GRAD_W = 12;   // signed Sobel sum, |g| <= 1020
  localparam int unsigned SQ_W   = 22;   // gx^2 + gy^2 <= 2080800
  localparam int unsigned BIT_W  = 23;   // root bit mask, starts at 1 << 22
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] ROOT_LAST_STEP = 4'd11;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SQ,
    S_SUM,
    S_ROOT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;     // take a word, read line buffers, advance counters
    logic proc;       // shift window, write line buffers, form gradients
    logic square;
    logic sum;        // add squares, start root
    logic root_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic has_out;
    logic root_last;
    logic out_free;
  } dp_stat_t;

  // position flags captured when a word is taken
  typedef struct packed {
    logic out_a;      // column 0: result for the last column of an older row
    logic out_b;      // interior: result for the previous column
    logic top_a;
    logic bot_a;
    logic top_b;
    logic bot_b;
    logic left_refl;
    logic frame_end;
  } pos_flags_t;

endpackage
`default_nettype wire

// ----- rtl/sem_pix_if.sv -----
`default_nettype none
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface
`default_nettype wire

// ----- rtl/sem_edge_if.sv -----
`default_nettype none
interface sem_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_value;
  logic       frame_end;

  modport source (output valid, output edge_value, output frame_end, input ready);
  modport sink   (input valid, input edge_value, input frame_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/sem_ctrl.sv -----
`default_nettype none
module sem_ctrl
  import sem_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOAD;
      S_LOAD: state_d = stat_i.has_out ? S_SQ : S_IDLE;
      S_SQ:   state_d = S_SUM;
      S_SUM:  state_d = S_ROOT;
      S_ROOT: if (stat_i.root_last) state_d = S_DONE;
      S_DONE: if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_LOAD: cmd_o.proc      = 1'b1;
      S_SQ:   cmd_o.square    = 1'b1;
      S_SUM:  cmd_o.sum       = 1'b1;
      S_ROOT: cmd_o.root_step = 1'b1;
      S_DONE: cmd_o.out_load  = stat_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/sem_datapath.sv -----
`default_nettype none
module sem_datapath
  import sem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                 mode_i,
  input  wire logic [PIX_W-1:0]     pixel_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [PIX_W-1:0]          edge_value_o,
  output logic                      frame_end_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [11:0] img_w_q;
  logic [15:0] img_h_q;
  logic        thr_en_q;
  logic [10:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= 12'd640;
      img_h_q  <= 16'd480;
      thr_en_q <= 1'b0;
      thr_q    <= 11'd40;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:      img_w_q  <= cfg_data_i[11:0];
        CFG_IMAGE_HEIGHT:     img_h_q  <= cfg_data_i;
        CFG_THRESHOLD_ENABLE: thr_en_q <= cfg_data_i[0];
        CFG_EDGE_THRESHOLD:   thr_q    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [31:0] w_eff, iw32, c_next32;
  logic [16:0] h_eff;
  always_comb begin
    iw32  = 32'(img_w_q);
    w_eff = (iw32 < 32'd2) ? 32'd2 : ((iw32 > MAX_WIDTH) ? 32'(MAX_WIDTH) : iw32);
    h_eff = (img_h_q < 16'd2) ? 17'd2 : {1'b0, img_h_q};
  end

  // position counters and flags
  logic [CW-1:0] col_q;
  logic [16:0]   row_q;
  pos_flags_t    flags_q, flags_d;

  always_comb begin
    c_next32          = 32'(col_q) + 32'd1;
    flags_d.out_a     = (col_q == '0) && (row_q >= 17'd2);
    flags_d.out_b     = (col_q != '0) && (row_q >= 17'd1);
    flags_d.top_a     = (row_q == 17'd2);
    flags_d.bot_a     = ({1'b0, row_q} >= ({1'b0, h_eff} + 18'd1));
    flags_d.top_b     = (row_q == 17'd1);
    flags_d.bot_b     = (row_q >= h_eff);
    flags_d.left_refl = (col_q == CW'(1));
    flags_d.frame_end = flags_d.out_a && flags_d.bot_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flags_q <= '0;
    end else if (cmd_i.accept) begin
      flags_q <= flags_d;
      if (flags_d.frame_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (c_next32 >= w_eff) begin
        col_q <= '0;
        row_q <= row_q + 17'd1;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // line buffers: read on accept, written back in the next cycle (proc)
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q, pix_q;
  logic [CW-1:0]    addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      up_rd_q  <= upper_mem[col_q];
      mid_rd_q <= middle_mem[col_q];
      addr_q   <= col_q;
      pix_q    <= mode_i ? '0 : pixel_i;
    end
    if (cmd_i.proc) begin
      upper_mem[addr_q]  <= mid_rd_q;
      middle_mem[addr_q] <= pix_q;
    end
  end

  // 3x3 window, index row*3 + col, col 2 newest
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] nwin  [9];
  logic [PIX_W-1:0] src   [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nwin[i*3]   = win_q[i*3+1];
      nwin[i*3+1] = win_q[i*3+2];
    end
    nwin[2] = up_rd_q;
    nwin[5] = mid_rd_q;
    nwin[8] = pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cmd_i.proc) begin
      for (int i = 0; i < 9; i++) win_q[i] <= nwin[i];
    end
  end

  // neighborhood selection with border handling, then gradients
  logic signed [GRAD_W-1:0] p [3][3];
  logic [1:0]               cl, cm, cr;
  logic                     top, bot;
  logic signed [GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;

  always_comb begin
    if (flags_q.out_a) begin
      for (int i = 0; i < 9; i++) src[i] = win_q[i];
      cl  = 2'd1;
      cm  = 2'd2;
      cr  = 2'd2;
      top = flags_q.top_a;
      bot = flags_q.bot_a;
    end else begin
      for (int i = 0; i < 9; i++) src[i] = nwin[i];
      cl  = flags_q.left_refl ? 2'd2 : 2'd0;
      cm  = 2'd1;
      cr  = 2'd2;
      top = flags_q.top_b;
      bot = flags_q.bot_b;
    end
    for (int i = 0; i < 3; i++) begin
      p[i][0] = $signed({4'b0, src[i*3 + 32'(cl)]});
      p[i][1] = $signed({4'b0, src[i*3 + 32'(cm)]});
      p[i][2] = $signed({4'b0, src[i*3 + 32'(cr)]});
    end
    if (bot) for (int j = 0; j < 3; j++) p[2][j] = p[1][j];
    if (top) for (int j = 0; j < 3; j++) p[0][j] = p[2][j];
    gx_d = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
    gy_d = (p[2][0] - p[0][0]) + ((p[2][1] - p[0][1]) <<< 1) + (p[2][2] - p[0][2]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.proc) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  // squares and threshold square
  logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0] sqx_q, sqy_q, tt_q, s_q;
  assign sqx_full = gx_q * gx_q;
  assign sqy_full = gy_q * gy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sqx_q <= sqx_full[SQ_W-1:0];
      sqy_q <= sqy_full[SQ_W-1:0];
      tt_q  <= SQ_W'(thr_q * thr_q);
    end
  end

  // digit-by-digit square root, one bit pair per cycle
  logic [BIT_W:0]    v_q, res_q, bit_q, trial;
  logic [STEP_W-1:0] step_q;
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      s_q    <= sqx_q + sqy_q;
      v_q    <= (BIT_W+1)'(sqx_q) + (BIT_W+1)'(sqy_q);
      res_q  <= '0;
      bit_q  <= (BIT_W+1)'(1) << (BIT_W-1);
      step_q <= '0;
    end else if (cmd_i.root_step) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q  <= bit_q >> 2;
      step_q <= step_q + STEP_W'(1);
    end
  end

  // output register
  logic             out_valid_q;
  logic [PIX_W-1:0] edge_q, edge_d;
  logic             fend_q;

  always_comb begin
    if (thr_en_q) edge_d = (s_q > tt_q) ? 8'd255 : 8'd0;
    else          edge_d = (res_q > (BIT_W+1)'(255)) ? 8'd255 : res_q[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      edge_q <= edge_d;
      fend_q <= flags_q.frame_end;
    end
  end

  assign stat_o.has_out   = flags_q.out_a | flags_q.out_b;
  assign stat_o.root_last = (step_q == ROOT_LAST_STEP);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign edge_value_o     = edge_q;
  assign frame_end_o      = fend_q;

endmodule
`default_nettype wire

// ----- rtl/sobel_edge_magnitude_stream.sv -----
// Channel   Dir   Payload                      Handshake
// pix_in    in    mode, pixel_in               valid/ready
// edge_out  out   edge_value, frame_end        valid/ready
// cfg       in    cfg_index_i, cfg_data_i      cfg_we_i, no wait
//
// Every word passes buffer read and gradients; one that gives a result then goes
// on through squares, sum, 12 root steps of the bit-pair square root iteration and
// output. The line buffers need no clear.
// rst_ni clears counters, window and config to defaults. A stalled output
// holds the last stage until the result register frees up.
`default_nettype none
module sobel_edge_magnitude_stream
  import sem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  sem_pix_if.sink                   pix_in,
  sem_edge_if.source                edge_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_in.valid),
    .in_ready_o (pix_in.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (pix_in.mode),
    .pixel_i      (pix_in.pixel_in),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (edge_out.valid),
    .out_ready_i  (edge_out.ready),
    .edge_value_o (edge_out.edge_value),
    .frame_end_o  (edge_out.frame_end)
  );

endmodule
`default_nettype wire

// ----- sim/sobel_edge_magnitude_stream_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module sobel_edge_magnitude_stream_test;
  import sem_pkg::*;

  localparam int unsigned LINE_DEPTH = 2048;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       frame_end;
  } edge_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  sem_pix_if  pix_in ();
  sem_edge_if edge_out ();

  sobel_edge_magnitude_stream u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_in      (pix_in.sink),
    .edge_out    (edge_out.source)
  );

  // shadow of the block state
  logic [7:0]  upper_q [LINE_DEPTH];
  logic [7:0]  middle_q [LINE_DEPTH];
  logic [7:0]  win_q [9];
  int unsigned col_q, row_q;
  logic [11:0] width_q;
  logic [15:0] height_q;
  logic        thr_en_q;
  logic [10:0] thr_q;

  edge_word_t  edge_queue [$];
  int          fail_count = 0;
  bit          stall_sink = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #200ms;
    $display("sobel_edge_magnitude_stream_test: FAIL");
    $finish;
  end

  // Sobel magnitude for window columns l, m, r with border handling
  function automatic logic [7:0] sobel_mag(int l, int m, int r, bit top, bit bot);
    int p [3][3];
    int cols [3];
    int gx, gy;
    int unsigned s, root;
    cols = '{l, m, r};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) p[i][j] = win_q[i*3 + cols[j]];
    if (bot) for (int j = 0; j < 3; j++) p[2][j] = p[1][j];
    if (top) for (int j = 0; j < 3; j++) p[0][j] = p[2][j];
    gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
    gy = (p[2][0] - p[0][0]) + 2 * (p[2][1] - p[0][1]) + (p[2][2] - p[0][2]);
    s = gx * gx + gy * gy;
    if (thr_en_q) return (s > thr_q * thr_q) ? 8'd255 : 8'd0;
    root = 0;
    while ((root + 1) * (root + 1) <= s && root < 256) root++;
    return (root > 255) ? 8'd255 : root[7:0];
  endfunction

  // advance the shadow by one accepted word, queue any result
  task automatic predict_edge(logic flush, logic [7:0] pixel);
    int unsigned w, h, c, r, ci;
    logic [7:0] pix;
    bit done_frame;
    edge_word_t res;
    w = (width_q < 2) ? 2 : ((width_q > LINE_DEPTH) ? LINE_DEPTH : width_q);
    h = (height_q < 2) ? 2 : height_q;
    pix = flush ? 8'd0 : pixel;
    c = col_q;
    r = row_q;
    done_frame = 1'b0;
    if (c == 0 && r >= 2) begin
      res.edge_value = sobel_mag(1, 2, 2, r == 2, r >= h + 1);
      done_frame = (r >= h + 1);
      res.frame_end = done_frame;
      edge_queue.push_back(res);
    end
    ci = c % LINE_DEPTH;
    for (int i = 0; i < 3; i++) begin
      win_q[i*3] = win_q[i*3+1];
      win_q[i*3+1] = win_q[i*3+2];
    end
    win_q[2] = upper_q[ci];
    win_q[5] = middle_q[ci];
    win_q[8] = pix;
    upper_q[ci] = middle_q[ci];
    middle_q[ci] = pix;
    if (c >= 1 && r >= 1) begin
      res.edge_value = sobel_mag(c == 1 ? 2 : 0, 1, 2, r == 1, r >= h);
      res.frame_end = 1'b0;
      edge_queue.push_back(res);
    end
    if (done_frame) begin
      col_q = 0;
      row_q = 0;
    end else if (c + 1 >= w) begin
      col_q = 0;
      row_q = r + 1;
    end else begin
      col_q = c + 1;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    edge_word_t got, want;
    if (edge_out.valid && edge_out.ready) begin
      got.edge_value = edge_out.edge_value;
      got.frame_end = edge_out.frame_end;
      if (edge_queue.size() == 0) begin
        $error("unexpected word edge_value=%0d frame_end=%0d", got.edge_value, got.frame_end);
        fail_count++;
      end else begin
        want = edge_queue.pop_front();
        if (got.edge_value !== want.edge_value) begin
          $error("edge_value expected %0d actual %0d", want.edge_value, got.edge_value);
          fail_count++;
        end
        if (got.frame_end !== want.frame_end) begin
          $error("frame_end expected %0d actual %0d", want.frame_end, got.frame_end);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    edge_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_sink) edge_out.ready <= ($urandom_range(0, 3) != 0);
      else edge_out.ready <= 1'b1;
    end
  end

  int burst_left = 0;

  // send one word; gaps between bursts of random length
  task automatic send_pixel(logic flush, logic [7:0] pixel);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
    burst_left--;
    pix_in.valid <= 1'b1;
    pix_in.mode <= flush;
    pix_in.pixel_in <= pixel;
    do @(posedge clk_i); while (!pix_in.ready);
    predict_edge(flush, pixel);
    pix_in.valid <= 1'b0;
    // block is busy the cycle after a word is taken
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (edge_queue.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:      width_q = value[11:0];
      CFG_IMAGE_HEIGHT:     height_q = value;
      CFG_THRESHOLD_ENABLE: thr_en_q = value[0];
      default:              thr_q = value[10:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_frame(int w, int h, bit thr_en, int thr);
    write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DAT_W'(h));
    write_reg(CFG_THRESHOLD_ENABLE, CFG_DAT_W'(thr_en));
    write_reg(CFG_EDGE_THRESHOLD, CFG_DAT_W'(thr));
  endtask

  // one whole frame; kind 0 random, 1 extremes checker, 2 flat
  task automatic send_frame(int w, int h, int kind, bit drain_pixels);
    logic [7:0] p;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (kind)
          1: p = ((r + c) % 2) ? 8'hFF : 8'h00;
          2: p = 8'h80;
          default: p = 8'($urandom_range(0, 255));
        endcase
        send_pixel(1'b0, p);
      end
    for (int i = 0; i <= w; i++)
      if (drain_pixels) send_pixel(1'b0, 8'($urandom_range(0, 255)));
      else send_pixel(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // directed: extremes, thresholds, smallest frame, pixels during drain
  task automatic test_directed();
    set_frame(3, 2, 0, 0);
    send_frame(3, 2, 1, 0);
    send_frame(3, 2, 2, 1);
    wait_drained();
    set_frame(2, 2, 1, 0);
    send_frame(2, 2, 1, 0);
    wait_drained();
    write_reg(CFG_EDGE_THRESHOLD, CFG_DAT_W'(1442));
    send_frame(2, 2, 0, 0);
    wait_drained();
  endtask

  // out-of-range sizes saturate to the minimum
  task automatic test_saturation();
    set_frame(0, 1, 0, 40);
    send_frame(2, 2, 0, 0);
    wait_drained();
  endtask

  // random frames in both modes, sender holds off for a full drain after every frame
  task automatic test_random();
    int sent;
    int w, h;
    sent = 0;
    stall_sink = 1'b1;
    while (sent < 400) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(2, 8);
      h = $urandom_range(2, 6);
      set_frame(w, h, 1'($urandom_range(0, 1)), $urandom_range(0, 1442));
      send_frame(w, h, ($urandom_range(0, 7) == 0) ? 1 : 0, $urandom_range(0, 3) == 0);
      sent += w * h + w + 1;
      wait_drained();
    end
    stall_sink = 1'b0;
  endtask

  // wider frame, one row pair
  task automatic test_wide_frame();
    set_frame(64, 2, 1, 100);
    send_frame(64, 2, 0, 0);
    wait_drained();
  endtask

  initial begin
    pix_in.valid = 1'b0;
    pix_in.mode = 1'b0;
    pix_in.pixel_in = '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_q[i] = '0;
      middle_q[i] = '0;
    end
    for (int i = 0; i < 9; i++) win_q[i] = '0;
    col_q = 0;
    row_q = 0;
    width_q = 12'd640;
    height_q = 16'd480;
    thr_en_q = 1'b0;
    thr_q = 11'd40;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_random();
    test_wide_frame();
    wait_drained();
    if (fail_count == 0) $display("sobel_edge_magnitude_stream_test: PASS");
    else $display("sobel_edge_magnitude_stream_test: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
